// ===== rtl/frustum_cube_cull_assert.svh =====
// Assertion macros used by the checker file fcc_chk.
`ifndef FRUSTUM_CUBE_CULL_ASSERT_SVH
`define FRUSTUM_CUBE_CULL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define FCC_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/fcc_pkg.sv =====
package fcc_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int IDX_W       = 3;
    localparam int COEF_W      = 32;
    localparam int HALF_W      = 31;
    // corner coordinate: signed Q17.16
    localparam int COORD_W     = COEF_W + 1;
    localparam int PROD_W      = COEF_W + COORD_W;
    // three products plus the shifted constant term, exact
    localparam int ACC_W       = PROD_W + 2;
    localparam int FRAC_W      = 16;

    // input tdata layout, lowest bit first
    localparam int S_TDATA_W   = 264;
    localparam int OFS_IDX     = 0;
    localparam int OFS_A       = OFS_IDX + IDX_W;
    localparam int OFS_B       = OFS_A + COEF_W;
    localparam int OFS_C       = OFS_B + COEF_W;
    localparam int OFS_D       = OFS_C + COEF_W;
    localparam int OFS_CX      = OFS_D + COEF_W;
    localparam int OFS_CY      = OFS_CX + COEF_W;
    localparam int OFS_CZ      = OFS_CY + COEF_W;
    localparam int OFS_HALF    = OFS_CZ + COEF_W;

    localparam int M_TDATA_W   = 8;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TEST = 1'b1
    } t_op;

    typedef struct packed {
        logic [COEF_W-1:0] a;
        logic [COEF_W-1:0] b;
        logic [COEF_W-1:0] c;
        logic [COEF_W-1:0] d;
    } t_plane;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_coord;

endpackage

// ===== rtl/fcc_plane_eval.sv =====
module fcc_plane_eval (
    input  logic               i_clk,
    input  logic               i_en,
    input  fcc_pkg::t_plane    i_plane,
    input  fcc_pkg::t_coord    i_pos,
    input  fcc_pkg::t_coord    i_neg,
    output logic               o_cull
);

    logic signed [fcc_pkg::COEF_W-1:0]  w_a, w_b, w_c;
    logic signed [fcc_pkg::COORD_W-1:0] w_x, w_y, w_z;
    logic signed [fcc_pkg::PROD_W-1:0]  r_px, r_py, r_pz;
    logic        [fcc_pkg::COEF_W-1:0]  r_d;
    logic signed [fcc_pkg::ACC_W-1:0]   r_sum_xy, r_sum_zd;
    logic signed [fcc_pkg::ACC_W-1:0]   w_dq, w_total;
    logic                               r_cull;

    // pick the far corner on each axis by coefficient sign
    always_comb begin
        w_a = $signed(i_plane.a);
        w_b = $signed(i_plane.b);
        w_c = $signed(i_plane.c);
        w_x = $signed(i_plane.a[fcc_pkg::COEF_W-1] ? i_neg.x : i_pos.x);
        w_y = $signed(i_plane.b[fcc_pkg::COEF_W-1] ? i_neg.y : i_pos.y);
        w_z = $signed(i_plane.c[fcc_pkg::COEF_W-1] ? i_neg.z : i_pos.z);
    end

    // constant term moved to the product's binary point
    assign w_dq = $signed({{(fcc_pkg::ACC_W - fcc_pkg::COEF_W - fcc_pkg::FRAC_W)
                            {r_d[fcc_pkg::COEF_W-1]}},
                           r_d, {fcc_pkg::FRAC_W{1'b0}}});

    assign w_total = r_sum_xy + r_sum_zd;

    // multiply, add pairs, then take the sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px     <= w_a * w_x;
            r_py     <= w_b * w_y;
            r_pz     <= w_c * w_z;
            r_d      <= i_plane.d;
            r_sum_xy <= {{2{r_px[fcc_pkg::PROD_W-1]}}, r_px}
                      + {{2{r_py[fcc_pkg::PROD_W-1]}}, r_py};
            r_sum_zd <= {{2{r_pz[fcc_pkg::PROD_W-1]}}, r_pz} + w_dq;
            r_cull   <= w_total[fcc_pkg::ACC_W-1];
        end
    end

    assign o_cull = r_cull;

endmodule

// ===== rtl/frustum_cube_cull.sv =====
// Frustum culling of axis-aligned cubes against six stored planes. A request
// with tuser 0 writes one plane's coefficients (index above 5 is dropped) and
// gives no result; a request with tuser 1 tests a cube and gives one result
// whose bit 0 is 1 when the cube may be visible, 0 when it lies wholly behind
// some plane. Planes reset to zero, which leaves every cube visible. The block
// takes one request per clock when the output is not stalled; a test result
// passes through five register stages: corner offsets and plane snapshot,
// coefficient multiplies, pair sums, final sum and sign, and the output
// register. A plane write applies to every test taken after it and to none
// taken before it.
module frustum_cube_cull (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // plane_index, coef_a, coef_b, coef_c, coef_d, center_x, center_y,
    // center_z, half_size, zero pad
    input  logic [fcc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // operation
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // visible, zero pad
    output logic [fcc_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int NP = fcc_pkg::PLANE_COUNT;

    fcc_pkg::t_plane r_plane [NP];
    fcc_pkg::t_plane r_snap  [NP];
    fcc_pkg::t_plane w_new;
    fcc_pkg::t_coord r_pos, r_neg, n_pos, n_neg;
    logic [fcc_pkg::IDX_W-1:0]  w_idx;
    logic [fcc_pkg::COEF_W-1:0] w_cx, w_cy, w_cz;
    logic [fcc_pkg::HALF_W-1:0] w_half;
    logic [fcc_pkg::COORD_W-1:0] w_hx;
    logic [NP-1:0] w_cull;
    logic w_adv, w_acc, w_is_test;
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_out_vld, r_vis;

    // unpack the request
    always_comb begin
        w_idx   = s_axis_tdata[fcc_pkg::OFS_IDX +: fcc_pkg::IDX_W];
        w_new.a = s_axis_tdata[fcc_pkg::OFS_A +: fcc_pkg::COEF_W];
        w_new.b = s_axis_tdata[fcc_pkg::OFS_B +: fcc_pkg::COEF_W];
        w_new.c = s_axis_tdata[fcc_pkg::OFS_C +: fcc_pkg::COEF_W];
        w_new.d = s_axis_tdata[fcc_pkg::OFS_D +: fcc_pkg::COEF_W];
        w_cx    = s_axis_tdata[fcc_pkg::OFS_CX +: fcc_pkg::COEF_W];
        w_cy    = s_axis_tdata[fcc_pkg::OFS_CY +: fcc_pkg::COEF_W];
        w_cz    = s_axis_tdata[fcc_pkg::OFS_CZ +: fcc_pkg::COEF_W];
        w_half  = s_axis_tdata[fcc_pkg::OFS_HALF +: fcc_pkg::HALF_W];
        w_hx    = {{(fcc_pkg::COORD_W - fcc_pkg::HALF_W){1'b0}}, w_half};
        n_pos.x = {w_cx[fcc_pkg::COEF_W-1], w_cx} + w_hx;
        n_pos.y = {w_cy[fcc_pkg::COEF_W-1], w_cy} + w_hx;
        n_pos.z = {w_cz[fcc_pkg::COEF_W-1], w_cz} + w_hx;
        n_neg.x = {w_cx[fcc_pkg::COEF_W-1], w_cx} - w_hx;
        n_neg.y = {w_cy[fcc_pkg::COEF_W-1], w_cy} - w_hx;
        n_neg.z = {w_cz[fcc_pkg::COEF_W-1], w_cz} - w_hx;
    end

    // whole pipeline advances unless the result register is held
    assign w_adv         = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_acc         = s_axis_tvalid && w_adv;
    assign w_is_test     = (fcc_pkg::t_op'(s_axis_tuser) == fcc_pkg::OP_TEST);

    // plane store: write on an accepted load request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NP; p++) begin
                r_plane[p] <= '0;
            end
        end else if (w_acc && !w_is_test) begin
            for (int p = 0; p < NP; p++) begin
                if (w_idx == fcc_pkg::IDX_W'(p)) begin
                    r_plane[p] <= w_new;
                end
            end
        end
    end

    // stage 1: corner offsets and a snapshot of the planes
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pos <= n_pos;
            r_neg <= n_neg;
            for (int p = 0; p < NP; p++) begin
                r_snap[p] <= r_plane[p];
            end
        end
    end

    // one evaluator per plane, stages 2 to 4
    for (genvar p = 0; p < NP; p++) begin : g_plane
        fcc_plane_eval u_eval (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_plane (r_snap[p]),
            .i_pos   (r_pos),
            .i_neg   (r_neg),
            .o_cull  (w_cull[p])
        );
    end

    // valid bits travel with the data; output register holds under stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld  <= w_acc && w_is_test;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_out_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_vis <= ~|w_cull;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(fcc_pkg::M_TDATA_W - 1){1'b0}}, r_vis};

endmodule

// ===== rtl/fcc_chk.sv =====
`include "frustum_cube_cull_assert.svh"

module fcc_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [fcc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [fcc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // held result keeps its value
    `FCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    // a stalled result stalls the input side
    `FCC_ASSERT_NOW(a_stall_back, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "request taken while result held")
    // reset empties the pipeline
    `FCC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !m_axis_tvalid, "result valid after reset")
    // only the visible flag carries information
    `FCC_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[fcc_pkg::M_TDATA_W-1:1] == '0, "nonzero pad bits")

endmodule

bind frustum_cube_cull fcc_chk u_fcc_chk (.*);
